### hdl/dpsc_pkg.sv
package dpsc_pkg;

  // Result action codes
  localparam logic [1:0] ACT_NONE    = 2'd0;
  localparam logic [1:0] ACT_COMPARE = 2'd1;
  localparam logic [1:0] ACT_RAMP    = 2'd2;
  localparam logic [1:0] ACT_STOP    = 2'd3;

  // Run decision kept across items
  localparam logic [1:0] MODE_UNDECIDED = 2'd0;
  localparam logic [1:0] MODE_RUN       = 2'd1;
  localparam logic [1:0] MODE_STOP      = 2'd2;

  // Configuration register indexes
  localparam logic CFG_MAX_SPEED = 1'b0;
  localparam logic CFG_MIN_SPEED = 1'b1;

  localparam logic [15:0] MAX_SPEED_RESET = 16'd4300;
  localparam logic [15:0] MIN_SPEED_RESET = 16'd1200;

  // Duty band upper limits
  localparam logic [7:0] DUTY_FULL_HI   = 8'd5;
  localparam logic [7:0] DUTY_LINEAR_HI = 8'd85;
  localparam logic [7:0] DUTY_MIN_HI    = 8'd91;
  localparam logic [7:0] DUTY_HYST_HI   = 8'd95;
  localparam logic [7:0] DUTY_STOP_HI   = 8'd100;

  // Reciprocals: x/80 = ((x>>4) * RECIP5) >> 22, x/6 = ((x>>1) * RECIP3) >> 19
  localparam logic [19:0] RECIP5       = 20'd838861;
  localparam int          RECIP5_SHIFT = 22;
  localparam logic [17:0] RECIP3       = 18'd174763;
  localparam int          RECIP3_SHIFT = 19;

  // Controller to datapath commands
  typedef struct packed {
    logic load_in;
    logic step_div80;
    logic step_div6;
    logic load_out;
  } cmd_t;

endpackage

### hdl/dpsc_in_if.sv
interface dpsc_in_if;
  logic               valid;
  logic               ready;
  logic [7:0]         duty_percent;
  logic [15:0]        compare_value;
  logic signed [15:0] speed_reference;

  modport source (output valid, duty_percent, compare_value, speed_reference, input ready);
  modport sink (input valid, duty_percent, compare_value, speed_reference, output ready);
endinterface

### hdl/dpsc_out_if.sv
interface dpsc_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic [15:0]        compare_out;
  logic signed [14:0] speed_command;
  logic [16:0]        ramp_time_ms;

  modport source (output valid, action, compare_out, speed_command, ramp_time_ms,
                  input ready);
  modport sink (input valid, action, compare_out, speed_command, ramp_time_ms,
                output ready);
endinterface

### hdl/dpsc_ctrl.sv
module dpsc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output dpsc_pkg::cmd_t     cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_DIV80 = 2'd1;
  localparam logic [1:0] ST_DIV6  = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_full;
  logic       out_free;

  assign in_ready  = (state == ST_IDLE);
  assign out_valid = out_full;
  assign out_free  = !out_full || out_ready;

  // Issue one command per state
  always_comb begin
    cmd            = '0;
    cmd.load_in    = (state == ST_IDLE) && in_valid;
    cmd.step_div80 = (state == ST_DIV80);
    cmd.step_div6  = (state == ST_DIV6);
    cmd.load_out   = (state == ST_FIN) && out_free;
  end

  // Advance through the division steps, hold in FIN while the result slot is taken
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_valid) state_next = ST_DIV80;
      ST_DIV80: state_next = ST_DIV6;
      ST_DIV6:  state_next = ST_FIN;
      ST_FIN:   if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      out_full <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) out_full <= 1'b1;
      else if (out_ready) out_full <= 1'b0;
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    cmd.load_in |=> state == ST_DIV80)
    else $error("accepted request did not start the divide sequence");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_full || out_ready))
    else $error("result register overwritten before it was taken");

  a_full_from_load: assert property (@(posedge clk) disable iff (rst)
    $rose(out_full) |-> $past(cmd.load_out))
    else $error("result valid rose without a load");

endmodule

### hdl/dpsc_datapath.sv
module dpsc_datapath (
  input  logic               clk,
  input  logic               rst,
  input  dpsc_pkg::cmd_t     cmd,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic [7:0]         duty_percent,
  input  logic [15:0]        compare_value,
  input  logic signed [15:0] speed_reference,
  output logic [1:0]         action,
  output logic [15:0]        compare_out,
  output logic signed [14:0] speed_command,
  output logic [16:0]        ramp_time_ms
);

  // Configuration and persistent state
  logic [15:0] max_speed;
  logic [15:0] min_speed;
  logic [7:0]  last_duty;
  logic [1:0]  run_mode;

  // Per-request working registers
  logic [1:0]  act_r;
  logic [15:0] cmp_r;
  logic [15:0] ref_r;
  logic [15:0] base_r;
  logic        lin_r;
  logic        neg_r;
  logic [23:0] prod_r;
  logic [17:0] q_r;
  logic [14:0] cmd_r;

  // Decision signals for the incoming request
  logic        changed;
  logic [1:0]  act_next;
  logic [1:0]  run_mode_next;
  logic        base_min;
  logic        lin_next;
  logic [16:0] diff;
  logic [16:0] diff_mag;
  logic [23:0] prod_next;

  // Divide by 80 step
  logic [19:0] y80;
  logic [39:0] p80;

  // Divide by 6 step
  logic [19:0] q_signed;
  logic [19:0] v;
  logic [19:0] v_mag;
  logic [17:0] z6;
  logic [35:0] p6;
  logic [16:0] q6;
  logic [14:0] cmd_next;

  // Ramp time
  logic [16:0] d17;
  logic [16:0] d_mag;
  logic [18:0] x5;

  // Pick the band outcome
  always_comb begin
    changed       = (duty_percent != last_duty);
    act_next      = dpsc_pkg::ACT_COMPARE;
    run_mode_next = run_mode;
    base_min      = 1'b0;
    lin_next      = 1'b0;
    if (!changed) begin
      act_next = dpsc_pkg::ACT_NONE;
    end else if (duty_percent <= dpsc_pkg::DUTY_FULL_HI) begin
      run_mode_next = dpsc_pkg::MODE_RUN;
      act_next      = dpsc_pkg::ACT_RAMP;
    end else if (duty_percent <= dpsc_pkg::DUTY_LINEAR_HI) begin
      run_mode_next = dpsc_pkg::MODE_RUN;
      act_next      = dpsc_pkg::ACT_RAMP;
      lin_next      = 1'b1;
    end else if (duty_percent <= dpsc_pkg::DUTY_MIN_HI) begin
      run_mode_next = dpsc_pkg::MODE_RUN;
      act_next      = dpsc_pkg::ACT_RAMP;
      base_min      = 1'b1;
    end else if (duty_percent <= dpsc_pkg::DUTY_HYST_HI) begin
      // Hysteresis band: keep the earlier run or stop decision
      base_min = 1'b1;
      if (run_mode == dpsc_pkg::MODE_RUN) act_next = dpsc_pkg::ACT_RAMP;
      else if (run_mode == dpsc_pkg::MODE_STOP) act_next = dpsc_pkg::ACT_STOP;
    end else if (duty_percent <= dpsc_pkg::DUTY_STOP_HI) begin
      run_mode_next = dpsc_pkg::MODE_STOP;
      act_next      = dpsc_pkg::ACT_STOP;
    end
  end

  // Magnitude of (max - min) times duty
  always_comb begin
    diff      = {1'b0, max_speed} - {1'b0, min_speed};
    diff_mag  = diff[16] ? (17'd0 - diff) : diff;
    prod_next = diff_mag[15:0] * duty_percent;
  end

  // Truncating divide by 80 of the magnitude
  always_comb begin
    y80 = prod_r[23:4];
    p80 = y80 * dpsc_pkg::RECIP5;
  end

  // Apply sign, subtract from base, truncating divide by 6
  always_comb begin
    q_signed = neg_r ? (20'd0 - {2'b0, q_r}) : {2'b0, q_r};
    v        = {4'b0, base_r} - q_signed;
    v_mag    = v[19] ? (20'd0 - v) : v;
    z6       = v_mag[18:1];
    p6       = z6 * dpsc_pkg::RECIP3;
    q6       = p6[35:dpsc_pkg::RECIP3_SHIFT];
    cmd_next = v[19] ? (15'd0 - q6[14:0]) : q6[14:0];
  end

  // |command - reference| * 5 / 2
  always_comb begin
    d17   = {{2{cmd_r[14]}}, cmd_r} - {ref_r[15], ref_r};
    d_mag = d17[16] ? (17'd0 - d17) : d17;
    x5    = {2'b0, d_mag} + {d_mag, 2'b00};
  end

  // Control state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      max_speed <= dpsc_pkg::MAX_SPEED_RESET;
      min_speed <= dpsc_pkg::MIN_SPEED_RESET;
      last_duty <= '0;
      run_mode  <= dpsc_pkg::MODE_UNDECIDED;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          dpsc_pkg::CFG_MAX_SPEED: max_speed <= cfg_data;
          dpsc_pkg::CFG_MIN_SPEED: min_speed <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.load_in) begin
        last_duty <= duty_percent;
        run_mode  <= run_mode_next;
      end
    end
  end

  // Working and result registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      act_r  <= act_next;
      cmp_r  <= compare_value;
      ref_r  <= speed_reference;
      base_r <= base_min ? min_speed : max_speed;
      lin_r  <= lin_next;
      neg_r  <= diff[16];
      prod_r <= prod_next;
    end
    if (cmd.step_div80) begin
      q_r <= lin_r ? p80[39:dpsc_pkg::RECIP5_SHIFT] : 18'd0;
    end
    if (cmd.step_div6) begin
      cmd_r <= cmd_next;
    end
    if (cmd.load_out) begin
      action        <= act_r;
      compare_out   <= (act_r == dpsc_pkg::ACT_NONE) ? 16'd0 : cmp_r;
      speed_command <= (act_r == dpsc_pkg::ACT_RAMP) ? cmd_r : 15'd0;
      ramp_time_ms  <= (act_r == dpsc_pkg::ACT_RAMP) ? x5[17:1] : 17'd0;
    end
  end

  a_run_mode_legal: assert property (@(posedge clk) disable iff (rst)
    run_mode != 2'd3)
    else $error("run mode took an unused code");

  a_unchanged_zero: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out && act_r == dpsc_pkg::ACT_NONE |=>
      compare_out == 16'd0 && speed_command == 15'd0 && ramp_time_ms == 17'd0)
    else $error("unchanged duty produced nonzero result fields");

  a_same_duty_none: assert property (@(posedge clk) disable iff (rst)
    cmd.load_in && duty_percent == last_duty |=> act_r == dpsc_pkg::ACT_NONE)
    else $error("repeated duty did not yield no-change");

endmodule

### hdl/duty_to_pump_speed_command.sv
// Duty to pump speed command.
// Request channel (item): measured duty percent, timer compare value and the
// motor's signed speed reference. Result channel (result): action code,
// compare value to write, target speed command and ramp time in ms.
// Both channels use valid/ready; a request or result moves when both are high.
// The config port (cfg_we, cfg_index, cfg_data) writes max speed (index 0) or
// min speed (index 1); write it only while no request is in flight.
// Every request yields exactly one result. A request is taken in the idle
// state, then goes through the divide-by-80 and divide-by-6 reciprocal
// multiplier steps and a final step that forms the ramp time and loads the
// output register. A new request is taken only after the final step has
// loaded the output register and returned to idle.
// The result sits in an output register; if the receiver stalls, the next
// request still runs its divide steps and waits in the final step until the
// output register is taken.
// Reset (rst, synchronous) restores max 4300 and min 1200 rpm, clears the
// last duty to zero and the run decision to undecided, and empties the
// output register.
module duty_to_pump_speed_command (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  dpsc_in_if.sink     item,
  dpsc_out_if.source  result
);

  dpsc_pkg::cmd_t cmd;

  dpsc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .cmd       (cmd)
  );

  dpsc_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .duty_percent    (item.duty_percent),
    .compare_value   (item.compare_value),
    .speed_reference (item.speed_reference),
    .action          (result.action),
    .compare_out     (result.compare_out),
    .speed_command   (result.speed_command),
    .ramp_time_ms    (result.ramp_time_ms)
  );

endmodule

### tb/duty_to_pump_speed_command_tb.sv
`timescale 1ns / 1ps

module duty_to_pump_speed_command_tb;

  typedef struct packed {
    logic [1:0]         action;
    logic [15:0]        compare_out;
    logic signed [14:0] speed_command;
    logic [16:0]        ramp_time_ms;
  } speed_result_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_data;

  dpsc_in_if  req_if ();
  dpsc_out_if res_if ();

  duty_to_pump_speed_command uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (req_if),
    .result    (res_if)
  );

  // Shadow copy of the block's registers and state
  logic [15:0] max_rpm;
  logic [15:0] min_rpm;
  logic [7:0]  last_duty_seen;
  logic [1:0]  run_decision;

  speed_result_t expected_commands[$];
  int          mismatch_count = 0;
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  int          rx_hold_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Work out the result of one request and advance the shadow state
  function automatic speed_result_t predict_command(input logic [7:0] duty,
                                                    input logic [15:0] cmp,
                                                    input logic signed [15:0] sref);
    speed_result_t r;
    int            mx;
    int            mn;
    int            cmd;
    int            diff;
    logic          ramp;
    r    = '0;
    mx   = int'(max_rpm);
    mn   = int'(min_rpm);
    cmd  = 0;
    ramp = 1'b0;
    if (duty == last_duty_seen) return r;
    last_duty_seen = duty;
    r.action = dpsc_pkg::ACT_COMPARE;
    if (duty <= dpsc_pkg::DUTY_FULL_HI) begin
      run_decision = dpsc_pkg::MODE_RUN;
      cmd  = mx / 6;
      ramp = 1'b1;
    end else if (duty <= dpsc_pkg::DUTY_LINEAR_HI) begin
      run_decision = dpsc_pkg::MODE_RUN;
      cmd  = (mx - ((mx - mn) * int'(duty)) / 80) / 6;
      ramp = 1'b1;
    end else if (duty <= dpsc_pkg::DUTY_MIN_HI) begin
      run_decision = dpsc_pkg::MODE_RUN;
      cmd  = mn / 6;
      ramp = 1'b1;
    end else if (duty <= dpsc_pkg::DUTY_HYST_HI) begin
      // Keep the previous run or stop decision
      if (run_decision == dpsc_pkg::MODE_RUN) begin
        cmd  = mn / 6;
        ramp = 1'b1;
      end else if (run_decision == dpsc_pkg::MODE_STOP) begin
        r.action = dpsc_pkg::ACT_STOP;
      end
    end else if (duty <= dpsc_pkg::DUTY_STOP_HI) begin
      run_decision = dpsc_pkg::MODE_STOP;
      r.action = dpsc_pkg::ACT_STOP;
    end
    r.compare_out = cmp;
    if (ramp) begin
      diff = cmd - int'(sref);
      if (diff < 0) diff = -diff;
      r.action        = dpsc_pkg::ACT_RAMP;
      r.speed_command = cmd[14:0];
      r.ramp_time_ms  = 17'((diff * 1000) / 400);
    end
    return r;
  endfunction

  // Offer one request, wait for acceptance, record its expected result
  task automatic send_item(input logic [7:0] duty, input logic [15:0] cmp,
                           input logic signed [15:0] sref);
    @(negedge clk);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      req_if.valid = 1'b0;
      @(negedge clk);
    end
    req_if.valid           = 1'b1;
    req_if.duty_percent    = duty;
    req_if.compare_value   = cmp;
    req_if.speed_reference = sref;
    do @(posedge clk); while (!req_if.ready);
    expected_commands.push_back(predict_command(duty, cmp, sref));
  endtask

  // Drop valid and hold until every expected result has come
  task automatic wait_drain();
    @(negedge clk);
    req_if.valid = 1'b0;
    while (expected_commands.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Write both speed registers while the block is idle
  task automatic set_speeds(input logic [15:0] max_val, input logic [15:0] min_val);
    wait_drain();
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = dpsc_pkg::CFG_MAX_SPEED;
    cfg_data  = max_val;
    @(negedge clk);
    cfg_index = dpsc_pkg::CFG_MIN_SPEED;
    cfg_data  = min_val;
    @(negedge clk);
    cfg_we    = 1'b0;
    max_rpm   = max_val;
    min_rpm   = min_val;
  endtask

  // Spread duties over every band, with some repeats and out-of-range values
  function automatic logic [7:0] pick_duty();
    int sel;
    sel = $urandom_range(99);
    if (sel < 10) return last_duty_seen;
    if (sel < 25) return 8'($urandom_range(5));
    if (sel < 55) return 8'($urandom_range(85, 6));
    if (sel < 65) return 8'($urandom_range(91, 86));
    if (sel < 78) return 8'($urandom_range(95, 92));
    if (sel < 90) return 8'($urandom_range(100, 96));
    return 8'($urandom_range(255, 101));
  endfunction

  function automatic logic [15:0] pick_word();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'hffff;
      3: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_random(input int count);
    repeat (count) send_item(pick_duty(), pick_word(), pick_word());
  endtask

  // Walk every band, including the undecided hysteresis case after reset
  task automatic test_directed_bands();
    logic [7:0] duties[$] = '{8'd0, 8'd93, 8'd255, 8'd94, 8'd0, 8'd5, 8'd5, 8'd6,
                              8'd85, 8'd86, 8'd91, 8'd92, 8'd96, 8'd95, 8'd100,
                              8'd101, 8'd170, 8'd93, 8'd3, 8'd42, 8'd128};
    foreach (duties[i])
      send_item(duties[i], (i % 2) ? 16'hffff : 16'h0000,
                (i % 3 == 0) ? 16'sh8000 : ((i % 3 == 1) ? 16'sh7fff : 16'sh0000));
  endtask

  // Sweep the linear band under extreme register settings
  task automatic test_speed_extremes();
    logic [15:0] maxes[5] = '{16'd0, 16'd65535, 16'd0, 16'd65535, 16'd2500};
    logic [15:0] mins[5]  = '{16'd0, 16'd0, 16'd65535, 16'd65535, 16'd9000};
    logic [7:0]  sweep[8] = '{8'd0, 8'd6, 8'd7, 8'd40, 8'd79, 8'd80, 8'd84, 8'd85};
    for (int s = 0; s < 5; s++) begin
      set_speeds(maxes[s], mins[s]);
      foreach (sweep[i]) send_item(sweep[i], pick_word(), (i % 2) ? 16'sh8000 : 16'sh7fff);
      send_random(8);
    end
    set_speeds(dpsc_pkg::MAX_SPEED_RESET, dpsc_pkg::MIN_SPEED_RESET);
  endtask

  task automatic test_random_traffic(input int count, input int tx_pct, input int rx_pct);
    set_speeds(16'($urandom), 16'($urandom));
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    send_random(count);
    wait_drain();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
  endtask

  // Hold off the receiver long enough for the block to stall its input
  task automatic test_result_stall();
    @(posedge clk);
    rx_hold_left = 120;
    send_random(30);
    wait_drain();
  endtask

  // Pause the sender until every result is back, then resume
  task automatic test_drain_pause();
    send_random(10);
    wait_drain();
    send_random(10);
    wait_drain();
  endtask

  // Drive ready at the falling edge
  always @(negedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
    end else if (rx_hold_left > 0) begin
      res_if.ready <= 1'b0;
      rx_hold_left <= rx_hold_left - 1;
    end else begin
      res_if.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    speed_result_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      if (expected_commands.size() == 0) begin
        $display("%0t: unexpected result action %0d compare %h", $time,
                 res_if.action, res_if.compare_out);
        mismatch_count++;
      end else begin
        want = expected_commands.pop_front();
        if (res_if.action !== want.action) begin
          $display("%0t: action expected %0d got %0d", $time, want.action, res_if.action);
          mismatch_count++;
        end
        if (res_if.compare_out !== want.compare_out) begin
          $display("%0t: compare_out expected %h got %h", $time, want.compare_out,
                   res_if.compare_out);
          mismatch_count++;
        end
        if (res_if.speed_command !== want.speed_command) begin
          $display("%0t: speed_command expected %0d got %0d", $time, want.speed_command,
                   res_if.speed_command);
          mismatch_count++;
        end
        if (res_if.ramp_time_ms !== want.ramp_time_ms) begin
          $display("%0t: ramp_time_ms expected %0d got %0d", $time, want.ramp_time_ms,
                   res_if.ramp_time_ms);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    rst                    = 1'b1;
    cfg_we                 = 1'b0;
    cfg_index              = dpsc_pkg::CFG_MAX_SPEED;
    cfg_data               = '0;
    req_if.valid           = 1'b0;
    req_if.duty_percent    = '0;
    req_if.compare_value   = '0;
    req_if.speed_reference = '0;
    res_if.ready           = 1'b0;
    max_rpm                = dpsc_pkg::MAX_SPEED_RESET;
    min_rpm                = dpsc_pkg::MIN_SPEED_RESET;
    last_duty_seen         = '0;
    run_decision           = dpsc_pkg::MODE_UNDECIDED;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed_bands();
    wait_drain();
    test_speed_extremes();
    test_random_traffic(300, 13, 71);
    test_random_traffic(300, 71, 13);
    test_random_traffic(300, 0, 0);
    test_result_stall();
    test_drain_pause();

    if (mismatch_count == 0) begin
      $display("** duty_to_pump_speed_command: PASSED **");
    end else begin
      $display("** duty_to_pump_speed_command: FAILED **");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #2ms;
    $display("** duty_to_pump_speed_command: FAILED **");
    $finish;
  end

endmodule
